[src/pcm_pkg.sv]
package pcm_pkg;

	localparam int COORD_W       = 32;
	localparam int CFG_W         = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int FRAC_BITS_DEF = 16;
	// re and im are held to this many signed bits
	localparam int WORK_BITS     = 48;
	localparam int DEN_W         = 2 * WORK_BITS;
	// one quotient bit above the 32-bit result range, for the clamp check
	localparam int QUO_BITS      = COORD_W + 1;
	localparam int MUL_CHUNK     = 32;
	localparam int MUL_LAT       = 4;

	localparam logic [CFG_IDX_W-1:0] CFG_LINEAR = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SQUARE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AMOUNT = 2'd2;

	typedef struct packed {
		logic neg_x;
		logic neg_y;
		logic ovf_x;
		logic ovf_y;
		logic flag;
		logic dz;
	} div_side_t;

	typedef struct packed {
		logic [DEN_W-1:0]    rem_x;
		logic [DEN_W-1:0]    rem_y;
		logic [DEN_W-1:0]    den;
		logic [QUO_BITS-1:0] q_x;
		logic [QUO_BITS-1:0] q_y;
		logic [QUO_BITS-1:0] bits_x;
		logic [QUO_BITS-1:0] bits_y;
		div_side_t           side;
	} div_pl_t;

endpackage

[src/pcm_ifs.sv]
interface pcm_in_if import pcm_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;

	modport source (output valid, point_x, point_y, input ready);
	modport sink (input valid, point_x, point_y, output ready);
endinterface

interface pcm_out_if import pcm_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [COORD_W-1:0] mapped_x;
	logic signed [COORD_W-1:0] mapped_y;
	logic                      saturated;

	modport source (output valid, mapped_x, mapped_y, saturated, input ready);
	modport sink (input valid, mapped_x, mapped_y, saturated, output ready);
endinterface

[src/pcm_delay.sv]
module pcm_delay #(
	parameter int W     = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				line_q[k] <= line_q[k-1];
			end
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

[src/pcm_mul.sv]
module pcm_mul import pcm_pkg::*; #(
	parameter int A_W = 32,
	parameter int B_W = 32
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [A_W-1:0] a,
	input  logic signed [B_W-1:0] b,
	output logic signed [A_W+B_W-1:0] p
);

	localparam int NA = (A_W + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int NB = (B_W + MUL_CHUNK - 1) / MUL_CHUNK;
	localparam int AE = NA * MUL_CHUNK;
	localparam int BE = NB * MUL_CHUNK;
	localparam int SW = AE + BE;
	localparam int PW = A_W + B_W;

	logic [A_W-1:0]         mag_a;
	logic [B_W-1:0]         mag_b;
	logic [AE-1:0]          ma_s1;
	logic [BE-1:0]          mb_s1;
	logic                   neg_s1, neg_s2, neg_s3;
	logic [2*MUL_CHUNK-1:0] pp_s2 [NA*NB];
	logic [SW-1:0]          sum_c;
	logic [PW-1:0]          sum_s3;
	logic signed [PW-1:0]   p_s4;

	assign mag_a = a[A_W-1] ? A_W'(-a) : A_W'(a);
	assign mag_b = b[B_W-1] ? B_W'(-b) : B_W'(b);

	// shifted sum of the 32x32 partial products
	always_comb begin
		sum_c = '0;
		for (int i = 0; i < NA; i++) begin
			for (int j = 0; j < NB; j++) begin
				sum_c = sum_c + (SW'(pp_s2[i*NB+j]) << (MUL_CHUNK * (i + j)));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ma_s1  <= AE'(mag_a);
			mb_s1  <= BE'(mag_b);
			neg_s1 <= a[A_W-1] ^ b[B_W-1];
			for (int i = 0; i < NA; i++) begin
				for (int j = 0; j < NB; j++) begin
					pp_s2[i*NB+j] <= ma_s1[i*MUL_CHUNK +: MUL_CHUNK]
						* mb_s1[j*MUL_CHUNK +: MUL_CHUNK];
				end
			end
			neg_s2 <= neg_s1;
			sum_s3 <= sum_c[PW-1:0];
			neg_s3 <= neg_s2;
			p_s4   <= neg_s3 ? PW'(-sum_s3) : sum_s3;
		end
	end

	assign p = p_s4;

endmodule

[src/pcm_div_cell.sv]
module pcm_div_cell import pcm_pkg::*; (
	input  logic    clk,
	input  logic    en,
	input  div_pl_t d,
	output div_pl_t q
);

	div_pl_t          nxt_c;
	div_pl_t          q_s1;
	logic [DEN_W:0]   tx_c, ty_c, dw_c;

	// one restoring step per lane
	always_comb begin
		nxt_c = d;
		dw_c  = {1'b0, d.den};
		tx_c  = {d.rem_x, d.bits_x[QUO_BITS-1]};
		ty_c  = {d.rem_y, d.bits_y[QUO_BITS-1]};
		if (tx_c >= dw_c) begin
			nxt_c.rem_x = DEN_W'(tx_c - dw_c);
			nxt_c.q_x   = {d.q_x[QUO_BITS-2:0], 1'b1};
		end else begin
			nxt_c.rem_x = tx_c[DEN_W-1:0];
			nxt_c.q_x   = {d.q_x[QUO_BITS-2:0], 1'b0};
		end
		if (ty_c >= dw_c) begin
			nxt_c.rem_y = DEN_W'(ty_c - dw_c);
			nxt_c.q_y   = {d.q_y[QUO_BITS-2:0], 1'b1};
		end else begin
			nxt_c.rem_y = ty_c[DEN_W-1:0];
			nxt_c.q_y   = {d.q_y[QUO_BITS-2:0], 1'b0};
		end
		nxt_c.bits_x = {d.bits_x[QUO_BITS-2:0], 1'b0};
		nxt_c.bits_y = {d.bits_y[QUO_BITS-2:0], 1'b0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= nxt_c;
		end
	end

	assign q = q_s1;

endmodule

[src/pre_curl_point_map_core.sv]
// channel     dir  payload                                 request accepted when
// point_in    in   point_x, point_y (s32 fixed point)      point_in.valid && point_in.ready
// point_out   out  mapped_x, mapped_y (s32), saturated     point_out.valid && point_out.ready
// cfg         in   cfg_idx, cfg_data                       cfg_we
//
// One request per cycle while no result waits at point_out; the pipe holds four
// multiplier passes, six single add/clamp stages and 33 divider cells (one
// quotient bit each) plus the output register.
// Reset (arst_n low) clears the valid chain and loads the register defaults.
// A waiting result holds the whole pipeline; point_in.ready drops with it.
module pre_curl_point_map_core import pcm_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_data,
	pcm_in_if.sink               point_in,
	pcm_out_if.source            point_out
);

	// datapath widths
	localparam int SQ_W = 2 * COORD_W - FRAC_BITS;     // x^2-y^2 and x*y after shift
	localparam int P2_W = COORD_W + SQ_W;              // c2 * sq
	localparam int P3_W = COORD_W + 1 + SQ_W;          // 2*c2 * xy
	localparam int RW   = P3_W - FRAC_BITS + 2;        // unclamped re / im
	localparam int CW   = (RW > WORK_BITS) ? RW : WORK_BITS;
	localparam int NX_W = COORD_W + WORK_BITS + 1;     // numerators
	localparam int PX_W = NX_W + CFG_W;                // numerator * amount

	// stage numbers, counted in clock edges after acceptance
	localparam int S_G1  = MUL_LAT;
	localparam int S_SH  = S_G1 + 1;
	localparam int S_G2  = S_SH + MUL_LAT;
	localparam int S_RW  = S_G2 + 1;
	localparam int S_CL  = S_RW + 1;
	localparam int S_G3  = S_CL + MUL_LAT;
	localparam int S_SUM = S_G3 + 1;
	localparam int S_G4  = S_SUM + MUL_LAT;
	localparam int S_MAG = S_G4 + 1;
	localparam int S_INI = S_MAG + 1;
	localparam int S_DIV = S_INI + QUO_BITS;
	localparam int LAT   = S_DIV + 1;

	localparam logic [CFG_W-1:0] AMT_RESET =
		{{(CFG_W-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [RW-1:0] ONE_FX =
		{{(RW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
	localparam logic signed [CW-1:0] WHI =
		{{(CW-WORK_BITS+1){1'b0}}, {(WORK_BITS-1){1'b1}}};
	localparam logic signed [CW-1:0] WLO = ~WHI;
	localparam logic [COORD_W-1:0] MAX_POS = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] MIN_NEG = {1'b1, {(COORD_W-1){1'b0}}};

	// returns {clamped, value} for one coordinate
	function automatic logic [COORD_W:0] lane_out(logic neg, logic ovf,
			logic [QUO_BITS-1:0] q);
		logic [QUO_BITS-1:0] lim;
		logic                sat;
		logic [COORD_W-1:0]  v;
		lim = neg ? QUO_BITS'(MIN_NEG) : QUO_BITS'(MAX_POS);
		sat = ovf || (q > lim);
		if (sat) begin
			v = neg ? MIN_NEG : MAX_POS;
		end else begin
			v = neg ? COORD_W'(-q) : q[COORD_W-1:0];
		end
		return {sat, v};
	endfunction

	logic                      adv;
	logic [LAT-1:0]            vld_q;
	logic signed [CFG_W-1:0]   c1_q, c2_q, amt_q;
	logic signed [CFG_W:0]     c2x2;

	// --- configuration registers ---
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c1_q  <= '0;
			c2_q  <= '0;
			amt_q <= AMT_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_LINEAR: c1_q  <= cfg_data;
				CFG_SQUARE: c2_q  <= cfg_data;
				CFG_AMOUNT: amt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign c2x2 = {c2_q, 1'b0};

	// --- flow control: one enable for the whole pipe ---
	assign adv            = !point_out.valid || point_out.ready;
	assign point_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], point_in.valid};
		end
	end

	assign point_out.valid = vld_q[LAT-1];

	// --- pass 1: squares, cross term and c1 terms ---
	logic signed [2*COORD_W-1:0] pxx_s4, pyy_s4, pxy_s4, pc1x_s4, pc1y_s4;
	logic signed [2*COORD_W-1:0] dsq_c;

	pcm_mul #(.A_W(COORD_W), .B_W(COORD_W)) u_mul_xx (
		.clk(clk), .en(adv), .a(point_in.point_x), .b(point_in.point_x), .p(pxx_s4));
	pcm_mul #(.A_W(COORD_W), .B_W(COORD_W)) u_mul_yy (
		.clk(clk), .en(adv), .a(point_in.point_y), .b(point_in.point_y), .p(pyy_s4));
	pcm_mul #(.A_W(COORD_W), .B_W(COORD_W)) u_mul_xy (
		.clk(clk), .en(adv), .a(point_in.point_x), .b(point_in.point_y), .p(pxy_s4));
	pcm_mul #(.A_W(CFG_W), .B_W(COORD_W)) u_mul_c1x (
		.clk(clk), .en(adv), .a(c1_q), .b(point_in.point_x), .p(pc1x_s4));
	pcm_mul #(.A_W(CFG_W), .B_W(COORD_W)) u_mul_c1y (
		.clk(clk), .en(adv), .a(c1_q), .b(point_in.point_y), .p(pc1y_s4));

	// x^2 - y^2 cannot overflow 64 bits
	assign dsq_c = pxx_s4 - pyy_s4;

	logic signed [SQ_W-1:0] sq_s5, xy_s5, c1x_s5, c1y_s5;

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_s5  <= dsq_c[2*COORD_W-1:FRAC_BITS];
			xy_s5  <= pxy_s4[2*COORD_W-1:FRAC_BITS];
			c1x_s5 <= pc1x_s4[2*COORD_W-1:FRAC_BITS];
			c1y_s5 <= pc1y_s4[2*COORD_W-1:FRAC_BITS];
		end
	end

	// --- pass 2: c2 terms ---
	logic signed [P2_W-1:0]   p2_s9;
	logic signed [P3_W-1:0]   p3_s9;
	logic [2*SQ_W-1:0]        c1d_s9;
	logic signed [SQ_W-1:0]   c1x_s9, c1y_s9;
	logic signed [P2_W-FRAC_BITS-1:0] t2_c;
	logic signed [P3_W-FRAC_BITS-1:0] t3_c;

	pcm_mul #(.A_W(CFG_W), .B_W(SQ_W)) u_mul_c2sq (
		.clk(clk), .en(adv), .a(c2_q), .b(sq_s5), .p(p2_s9));
	pcm_mul #(.A_W(CFG_W+1), .B_W(SQ_W)) u_mul_c2xy (
		.clk(clk), .en(adv), .a(c2x2), .b(xy_s5), .p(p3_s9));

	pcm_delay #(.W(2*SQ_W), .DEPTH(S_G2-S_SH)) u_dly_c1 (
		.clk(clk), .en(adv), .d({c1x_s5, c1y_s5}), .q(c1d_s9));

	assign c1x_s9 = c1d_s9[2*SQ_W-1:SQ_W];
	assign c1y_s9 = c1d_s9[SQ_W-1:0];
	assign t2_c   = p2_s9[P2_W-1:FRAC_BITS];
	assign t3_c   = p3_s9[P3_W-1:FRAC_BITS];

	logic signed [RW-1:0] re_w_s10, im_w_s10;

	always_ff @(posedge clk) begin
		if (adv) begin
			re_w_s10 <= ONE_FX + RW'(c1x_s9) + RW'(t2_c);
			im_w_s10 <= RW'(c1y_s9) + RW'(t3_c);
		end
	end

	// --- clamp re and im to the working width ---
	logic signed [CW-1:0]        re_e_c, im_e_c, re_k_c, im_k_c;
	logic                        clamp_c;
	logic signed [WORK_BITS-1:0] re_s11, im_s11;
	logic                        flag_s11;

	always_comb begin
		re_e_c  = CW'(re_w_s10);
		im_e_c  = CW'(im_w_s10);
		clamp_c = 1'b0;
		re_k_c  = re_e_c;
		im_k_c  = im_e_c;
		if (re_e_c > WHI) begin
			re_k_c  = WHI;
			clamp_c = 1'b1;
		end else if (re_e_c < WLO) begin
			re_k_c  = WLO;
			clamp_c = 1'b1;
		end
		if (im_e_c > WHI) begin
			im_k_c  = WHI;
			clamp_c = 1'b1;
		end else if (im_e_c < WLO) begin
			im_k_c  = WLO;
			clamp_c = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			re_s11   <= re_k_c[WORK_BITS-1:0];
			im_s11   <= im_k_c[WORK_BITS-1:0];
			flag_s11 <= clamp_c;
		end
	end

	// --- pass 3: denominator squares and numerator products ---
	logic [2*COORD_W-1:0]              xyd_s11;
	logic signed [COORD_W-1:0]         x_s11, y_s11;
	logic signed [DEN_W-1:0]           rr_s15, ii_s15;
	logic signed [COORD_W+WORK_BITS-1:0] xre_s15, yim_s15, yre_s15, xim_s15;
	logic                              flag_s15;

	pcm_delay #(.W(2*COORD_W), .DEPTH(S_CL)) u_dly_xy (
		.clk(clk), .en(adv), .d({point_in.point_x, point_in.point_y}), .q(xyd_s11));

	assign x_s11 = xyd_s11[2*COORD_W-1:COORD_W];
	assign y_s11 = xyd_s11[COORD_W-1:0];

	pcm_mul #(.A_W(WORK_BITS), .B_W(WORK_BITS)) u_mul_rr (
		.clk(clk), .en(adv), .a(re_s11), .b(re_s11), .p(rr_s15));
	pcm_mul #(.A_W(WORK_BITS), .B_W(WORK_BITS)) u_mul_ii (
		.clk(clk), .en(adv), .a(im_s11), .b(im_s11), .p(ii_s15));
	pcm_mul #(.A_W(COORD_W), .B_W(WORK_BITS)) u_mul_xre (
		.clk(clk), .en(adv), .a(x_s11), .b(re_s11), .p(xre_s15));
	pcm_mul #(.A_W(COORD_W), .B_W(WORK_BITS)) u_mul_yim (
		.clk(clk), .en(adv), .a(y_s11), .b(im_s11), .p(yim_s15));
	pcm_mul #(.A_W(COORD_W), .B_W(WORK_BITS)) u_mul_yre (
		.clk(clk), .en(adv), .a(y_s11), .b(re_s11), .p(yre_s15));
	pcm_mul #(.A_W(COORD_W), .B_W(WORK_BITS)) u_mul_xim (
		.clk(clk), .en(adv), .a(x_s11), .b(im_s11), .p(xim_s15));

	pcm_delay #(.W(1), .DEPTH(S_G3-S_CL)) u_dly_flag (
		.clk(clk), .en(adv), .d(flag_s11), .q(flag_s15));

	logic [DEN_W-1:0]       den_s16;
	logic signed [NX_W-1:0] nx_s16, ny_s16;
	logic                   flag_s16;

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s16  <= rr_s15 + ii_s15;
			nx_s16   <= NX_W'(xre_s15) + NX_W'(yim_s15);
			ny_s16   <= NX_W'(yre_s15) - NX_W'(xim_s15);
			flag_s16 <= flag_s15;
		end
	end

	// --- pass 4: scale numerators by the amount ---
	logic signed [PX_W-1:0] px_s20, py_s20;
	logic [DEN_W:0]         dfd_s20;

	pcm_mul #(.A_W(NX_W), .B_W(CFG_W)) u_mul_nx (
		.clk(clk), .en(adv), .a(nx_s16), .b(amt_q), .p(px_s20));
	pcm_mul #(.A_W(NX_W), .B_W(CFG_W)) u_mul_ny (
		.clk(clk), .en(adv), .a(ny_s16), .b(amt_q), .p(py_s20));

	pcm_delay #(.W(DEN_W+1), .DEPTH(S_G4-S_SUM)) u_dly_den (
		.clk(clk), .en(adv), .d({den_s16, flag_s16}), .q(dfd_s20));

	// sign of the product decides the result sign; a zero product divides to zero
	logic [PX_W-1:0]  mag_x_s21, mag_y_s21;
	logic             neg_x_s21, neg_y_s21, flag_s21, dz_s21;
	logic [DEN_W-1:0] den_s21;

	always_ff @(posedge clk) begin
		if (adv) begin
			neg_x_s21 <= px_s20[PX_W-1];
			neg_y_s21 <= py_s20[PX_W-1];
			mag_x_s21 <= px_s20[PX_W-1] ? PX_W'(-px_s20) : px_s20;
			mag_y_s21 <= py_s20[PX_W-1] ? PX_W'(-py_s20) : py_s20;
			den_s21   <= dfd_s20[DEN_W:1];
			flag_s21  <= dfd_s20[0];
			dz_s21    <= (dfd_s20[DEN_W:1] == '0);
		end
	end

	// --- divider setup: high part must be below den, else the quotient is too big ---
	div_pl_t init_s22;

	always_ff @(posedge clk) begin
		if (adv) begin
			init_s22.rem_x      <= DEN_W'(mag_x_s21[PX_W-1:QUO_BITS]);
			init_s22.rem_y      <= DEN_W'(mag_y_s21[PX_W-1:QUO_BITS]);
			init_s22.den        <= den_s21;
			init_s22.q_x        <= '0;
			init_s22.q_y        <= '0;
			init_s22.bits_x     <= mag_x_s21[QUO_BITS-1:0];
			init_s22.bits_y     <= mag_y_s21[QUO_BITS-1:0];
			init_s22.side.neg_x <= neg_x_s21;
			init_s22.side.neg_y <= neg_y_s21;
			init_s22.side.ovf_x <= (mag_x_s21[PX_W-1:QUO_BITS] >= den_s21);
			init_s22.side.ovf_y <= (mag_y_s21[PX_W-1:QUO_BITS] >= den_s21);
			init_s22.side.flag  <= flag_s21;
			init_s22.side.dz    <= dz_s21;
		end
	end

	// --- divider: a row of cells, one quotient bit per cell ---
	div_pl_t div_q [QUO_BITS];

	for (genvar k = 0; k < QUO_BITS; k++) begin : g_div
		if (k == 0) begin : g_head
			pcm_div_cell u_cell (.clk(clk), .en(adv), .d(init_s22), .q(div_q[k]));
		end else begin : g_body
			pcm_div_cell u_cell (.clk(clk), .en(adv), .d(div_q[k-1]), .q(div_q[k]));
		end
	end

	// --- output register ---
	div_pl_t              fin_c;
	logic [COORD_W:0]     lx_c, ly_c;
	logic [COORD_W-1:0]   out_x_q, out_y_q;
	logic                 out_sat_q;

	assign fin_c = div_q[QUO_BITS-1];
	assign lx_c  = lane_out(fin_c.side.neg_x, fin_c.side.ovf_x, fin_c.q_x);
	assign ly_c  = lane_out(fin_c.side.neg_y, fin_c.side.ovf_y, fin_c.q_y);

	always_ff @(posedge clk) begin
		if (adv) begin
			if (fin_c.side.dz) begin
				// zero denominator: both coordinates pinned high
				out_x_q   <= MAX_POS;
				out_y_q   <= MAX_POS;
				out_sat_q <= 1'b1;
			end else begin
				out_x_q   <= lx_c[COORD_W-1:0];
				out_y_q   <= ly_c[COORD_W-1:0];
				out_sat_q <= lx_c[COORD_W] | ly_c[COORD_W] | fin_c.side.flag;
			end
		end
	end

	assign point_out.mapped_x  = out_x_q;
	assign point_out.mapped_y  = out_y_q;
	assign point_out.saturated = out_sat_q;

`ifndef SYNTHESIS
	a_rem_x: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[S_DIV-1] && !fin_c.side.ovf_x |-> fin_c.rem_x < fin_c.den)
		else $error("divider x remainder not below denominator");

	a_rem_y: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[S_DIV-1] && !fin_c.side.ovf_y |-> fin_c.rem_y < fin_c.den)
		else $error("divider y remainder not below denominator");

	a_dz_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && vld_q[S_DIV-1] && fin_c.side.dz |=> point_out.saturated
			&& point_out.mapped_x == MAX_POS && point_out.mapped_y == MAX_POS)
		else $error("zero denominator result not pinned");
`endif

endmodule
